@@ rtl/core/evh_pkg.sv @@
`timescale 1ns / 1ps

package evh_pkg;

    localparam int MAX_FRAME_SAMPLES_DEF = 4096;
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SILENCE_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VAD_ENABLE = 3'd0,
        REG_ENTER_THRESHOLD = 3'd1,
        REG_EXIT_THRESHOLD = 3'd2,
        REG_HANGOVER_MS = 3'd3,
        REG_FRAME_DURATION_MS = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic vad_enable;
        logic [15:0] enter_threshold;
        logic [15:0] exit_threshold;
        logic [15:0] hangover_ms;
        logic [7:0] frame_duration_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        vad_enable: 1'b1,
        enter_threshold: 16'd800,
        exit_threshold: 16'd500,
        hangover_ms: 16'd500,
        frame_duration_ms: 8'd20
    };

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

@@ rtl/core/evh_front.sv @@
`timescale 1ns / 1ps

module evh_front #(
    parameter int MAX_FRAME_SAMPLES = evh_pkg::MAX_FRAME_SAMPLES_DEF,
    parameter int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1),
    parameter int SUM_W = $clog2(64'd32768 * MAX_FRAME_SAMPLES + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [evh_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                         s_tlast,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [SUM_W+CNT_W:0]         q_data
);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic [evh_pkg::SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0] sum_upd;
    logic [CNT_W-1:0] count_upd;
    logic ovf_upd;
    logic accept;

    assign s_tready = !q_full;
    assign accept = s_tvalid && s_tready;
    assign mag = s_tdata[evh_pkg::SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;

    always_comb begin
        if (count_reg < CNT_W'(MAX_FRAME_SAMPLES)) begin
            sum_upd = sum_reg + SUM_W'(mag);
            count_upd = count_reg + 1'b1;
            ovf_upd = ovf_reg;
        end else begin
            sum_upd = sum_reg;
            count_upd = count_reg;
            ovf_upd = 1'b1;
        end
        sum_next = sum_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        q_push = 1'b0;
        if (accept) begin
            if (s_tlast) begin
                q_push = 1'b1;
                sum_next = '0;
                count_next = '0;
                ovf_next = 1'b0;
            end else begin
                sum_next = sum_upd;
                count_next = count_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    assign q_data = {ovf_upd, count_upd, sum_upd};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

@@ rtl/core/evh_queue.sv @@
`timescale 1ns / 1ps

module evh_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH = evh_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic do_push, do_pop;

    assign empty = (fill_reg == '0);
    assign full = (fill_reg == FILL_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ rtl/core/evh_back.sv @@
`timescale 1ns / 1ps

module evh_back #(
    parameter int MAX_FRAME_SAMPLES = evh_pkg::MAX_FRAME_SAMPLES_DEF,
    parameter int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1),
    parameter int SUM_W = $clog2(64'd32768 * MAX_FRAME_SAMPLES + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  logic [SUM_W+CNT_W:0]        q_data,
    output logic                        q_pop,
    input  evh_pkg::cfg_t               cfg,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [evh_pkg::LEVEL_W-1:0] m_tdata,
    output logic [2:0]                  m_tuser
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    evh_pkg::back_state_t state_reg, state_next;
    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic ovf_reg, ovf_next;
    logic speech_reg, speech_next;
    logic [evh_pkg::SILENCE_W-1:0] silence_reg, silence_next;
    logic out_valid_reg, out_valid_next;
    logic [evh_pkg::LEVEL_W-1:0] out_level_reg, out_level_next;
    logic [2:0] out_flags_reg, out_flags_next;

    logic [CNT_W:0] trial;
    logic ge;
    logic [evh_pkg::LEVEL_W-1:0] level;
    logic [evh_pkg::SILENCE_W:0] sil_sum;
    logic changed;

    assign trial = {rem_reg, dq_reg[SUM_W-1]};
    assign ge = (trial >= {1'b0, div_reg});
    assign level = dq_reg[evh_pkg::LEVEL_W-1:0];
    assign sil_sum = {1'b0, silence_reg} + (evh_pkg::SILENCE_W + 1)'(cfg.frame_duration_ms);

    always_comb begin
        state_next = state_reg;
        dq_next = dq_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        ovf_next = ovf_reg;
        speech_next = speech_reg;
        silence_next = silence_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_flags_next = out_flags_reg;
        q_pop = 1'b0;
        changed = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            evh_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    dq_next = q_data[SUM_W-1:0];
                    div_next = q_data[SUM_W +: CNT_W];
                    ovf_next = q_data[SUM_W+CNT_W];
                    rem_next = '0;
                    step_next = '0;
                    state_next = evh_pkg::BK_DIV;
                end
            end
            evh_pkg::BK_DIV: begin
                rem_next = ge ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
                dq_next = {dq_reg[SUM_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = evh_pkg::BK_DONE;
                end
            end
            evh_pkg::BK_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    if (cfg.vad_enable) begin
                        if (speech_reg) begin
                            if (level < cfg.exit_threshold) begin
                                if (sil_sum >= {1'b0, cfg.hangover_ms}) begin
                                    silence_next = cfg.hangover_ms;
                                    speech_next = 1'b0;
                                    changed = 1'b1;
                                end else begin
                                    silence_next = sil_sum[evh_pkg::SILENCE_W-1:0];
                                end
                            end else begin
                                silence_next = '0;
                            end
                        end else if (level >= cfg.enter_threshold) begin
                            speech_next = 1'b1;
                            silence_next = '0;
                            changed = 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    out_level_next = level;
                    out_flags_next = {ovf_reg, changed, speech_next};
                    state_next = evh_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = evh_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= evh_pkg::BK_IDLE;
            speech_reg <= 1'b0;
            silence_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            speech_reg <= speech_next;
            silence_reg <= silence_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg <= dq_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        step_reg <= step_next;
        ovf_reg <= ovf_next;
        out_level_reg <= out_level_next;
        out_flags_reg <= out_flags_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_level_reg;
    assign m_tuser = out_flags_reg;

    // A frame always holds at least one counted sample, so the divisor is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == evh_pkg::BK_IDLE && !q_empty) |-> (q_data[SUM_W +: CNT_W] != '0))
        else $error("frame record with zero sample count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == evh_pkg::BK_DIV) |-> (step_reg < STEP_W'(SUM_W)))
        else $error("divider step count out of range");

    // The mean magnitude can never exceed the largest sample magnitude.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == evh_pkg::BK_DONE) |-> (dq_reg <= SUM_W'(32768)))
        else $error("frame level above full scale");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]
            && $past(state_reg == evh_pkg::BK_DONE && (!out_valid_reg || m_tready)))
            |-> (m_tuser[0] != $past(speech_reg)))
        else $error("change flag without a speech state toggle");

endmodule

@@ rtl/core/energy_vad_hysteresis.sv @@
`timescale 1ns / 1ps
// Samples are taken one per cycle; the front stalls only while the two-entry frame queue is full.
// Each frame record then passes through the back end's idle, divide and done states; the
// restoring divider produces one quotient bit per cycle (SUM_W = 28 for 4096-sample frames).
// With an idle back end, m_tvalid rises from its output register, set in the done state.
// Reset (aresetn low, synchronous) restores register defaults, clears the accumulators,
// empties the queue and leaves the detector not speaking.

module energy_vad_hysteresis #(
    parameter int MAX_FRAME_SAMPLES = evh_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] sample
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [15:0] frame_level
    output logic [2:0]                     m_tuser,   // [0] speaking, [1] vad_changed, [2] overlong
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [evh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [evh_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W = $clog2(64'd32768 * MAX_FRAME_SAMPLES + 1);
    localparam int REC_W = SUM_W + CNT_W + 1;

    evh_pkg::cfg_t cfg_reg, cfg_next;
    logic q_push, q_pop, q_empty, q_full;
    logic [REC_W-1:0] q_in, q_out;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (evh_pkg::cfg_reg_t'(cfg_index))
                evh_pkg::REG_VAD_ENABLE: cfg_next.vad_enable = cfg_data[0];
                evh_pkg::REG_ENTER_THRESHOLD: cfg_next.enter_threshold = cfg_data;
                evh_pkg::REG_EXIT_THRESHOLD: cfg_next.exit_threshold = cfg_data;
                evh_pkg::REG_HANGOVER_MS: cfg_next.hangover_ms = cfg_data;
                evh_pkg::REG_FRAME_DURATION_MS: cfg_next.frame_duration_ms = cfg_data[7:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= evh_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    evh_front #(
        .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
        .CNT_W(CNT_W),
        .SUM_W(SUM_W)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .q_full(q_full),
        .q_push(q_push),
        .q_data(q_in)
    );

    evh_queue #(
        .DATA_W(REC_W),
        .DEPTH(evh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .push_data(q_in),
        .pop(q_pop),
        .pop_data(q_out),
        .empty(q_empty),
        .full(q_full)
    );

    evh_back #(
        .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
        .CNT_W(CNT_W),
        .SUM_W(SUM_W)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_data(q_out),
        .q_pop(q_pop),
        .cfg(cfg_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

endmodule

@@ bench/evh_frame_checker.sv @@
`timescale 1ns / 1ps

module evh_frame_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] sample
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,   // [15:0] frame_level
    input  logic [2:0]                     m_tuser,   // [0] speaking, [1] vad_changed, [2] overlong
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [evh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [evh_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             frames_due,
    output int                             frames_seen,
    output int                             toggles_seen,
    output int                             overlong_seen
);

    localparam int MAX_SAMPLES = evh_pkg::MAX_FRAME_SAMPLES_DEF;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [15:0] level;
        logic        speaking;
        logic        changed;
        logic        overlong;
    } frame_report_t;

    frame_report_t reports_due[$];
    evh_pkg::cfg_t regs;
    int unsigned   frame_sum;
    int unsigned   frame_count;
    int unsigned   quiet_ms;
    logic          in_speech;
    logic          dropped;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("MISMATCH at %0t ns, frame %0d: %s", $realtime, frames_seen, msg);
        end
    endtask

    task automatic absorb_sample(input logic [15:0] raw, input logic last);
        int unsigned   mag;
        int unsigned   level;
        int unsigned   quiet;
        frame_report_t rep;
        mag = raw[15] ? (32'h10000 - raw) : raw;
        if (frame_count < MAX_SAMPLES) begin
            frame_sum += mag;
            frame_count++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            level = frame_sum / frame_count;
            rep.changed = 1'b0;
            if (regs.vad_enable) begin
                if (in_speech) begin
                    if (level < regs.exit_threshold) begin
                        quiet = quiet_ms + regs.frame_duration_ms;
                        if (quiet >= regs.hangover_ms) begin
                            quiet = regs.hangover_ms;
                            in_speech = 1'b0;
                            rep.changed = 1'b1;
                        end
                        quiet_ms = quiet;
                    end else begin
                        quiet_ms = 0;
                    end
                end else if (level >= regs.enter_threshold) begin
                    in_speech = 1'b1;
                    quiet_ms = 0;
                    rep.changed = 1'b1;
                end
            end
            rep.level = level[15:0];
            rep.speaking = in_speech;
            rep.overlong = dropped;
            reports_due.push_back(rep);
            frame_sum = 0;
            frame_count = 0;
            dropped = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        frame_report_t want;
        if (!aresetn) begin
            regs = evh_pkg::CFG_RESET;
            frame_sum = 0;
            frame_count = 0;
            quiet_ms = 0;
            in_speech = 1'b0;
            dropped = 1'b0;
            reports_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    evh_pkg::REG_VAD_ENABLE: regs.vad_enable = cfg_data[0];
                    evh_pkg::REG_ENTER_THRESHOLD: regs.enter_threshold = cfg_data;
                    evh_pkg::REG_EXIT_THRESHOLD: regs.exit_threshold = cfg_data;
                    evh_pkg::REG_HANGOVER_MS: regs.hangover_ms = cfg_data;
                    evh_pkg::REG_FRAME_DURATION_MS: regs.frame_duration_ms = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    report_mismatch($sformatf("result with no frame pending, level %0d",
                                              m_tdata));
                end else begin
                    want = reports_due.pop_front();
                    if (m_tdata !== want.level) begin
                        report_mismatch($sformatf("frame_level %0d, expected %0d",
                                                  m_tdata, want.level));
                    end
                    if (m_tuser[0] !== want.speaking) begin
                        report_mismatch($sformatf("speaking %b, expected %b",
                                                  m_tuser[0], want.speaking));
                    end
                    if (m_tuser[1] !== want.changed) begin
                        report_mismatch($sformatf("vad_changed %b, expected %b",
                                                  m_tuser[1], want.changed));
                    end
                    if (m_tuser[2] !== want.overlong) begin
                        report_mismatch($sformatf("overlong %b, expected %b",
                                                  m_tuser[2], want.overlong));
                    end
                    frames_seen++;
                    toggles_seen += want.changed;
                    overlong_seen += want.overlong;
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_sample(s_tdata, s_tlast);
            end
        end
        frames_due = reports_due.size();
    end

endmodule

@@ bench/tb_energy_vad_hysteresis.sv @@
`timescale 1ns / 1ps

module tb_energy_vad_hysteresis;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASES = 8;
    localparam int HOLD_CYCLES = 700;
    localparam int SETTLE_CYCLES = 80;
    localparam int FULL_SCALE = 32768;
    localparam int OVERLONG_LEN = evh_pkg::MAX_FRAME_SAMPLES_DEF + 2;
    localparam logic [15:0] NEG_FULL = 16'h8000;
    localparam logic [15:0] POS_FULL = 16'h7FFF;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;   // [15:0] sample
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;   // [15:0] frame_level
    logic [2:0]                     m_tuser;   // [0] speaking, [1] vad_changed, [2] overlong
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [evh_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [evh_pkg::CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int frames_due;
    int frames_seen;
    int toggles_seen;
    int overlong_seen;

    int cycles;
    int items_sent;
    int writes_done;
    bit burst_mode;
    bit hold_wanted;
    bit hold_taken;
    int hold_left;
    int stall_left;
    int run_left;
    bit choppy;
    int enter_lvl;
    int exit_lvl;
    int hang_lvl;
    int step_ms;

    energy_vad_hysteresis dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    evh_frame_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .frames_due    (frames_due),
        .frames_seen   (frames_seen),
        .toggles_seen  (toggles_seen),
        .overlong_seen (overlong_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= LIMIT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 93) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_wanted && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (run_left == 0) begin
                run_left = $urandom_range(8, 80);
                choppy = ($urandom_range(0, 2) != 0);
                m_tready = 1'b1;
            end else begin
                run_left--;
                if (choppy && $urandom_range(0, 3) == 0) begin
                    stall_left = idle_len() - 1;
                    m_tready = 1'b0;
                end else begin
                    m_tready = 1'b1;
                end
            end
        end
    end

    task automatic send_sample(input logic [15:0] smp, input logic last);
        int gap;
        gap = 0;
        if (!burst_mode && $urandom_range(0, 3) == 0) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = smp;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_run(input logic [15:0] value, input int len);
        for (int k = 1; k <= len; k++) begin
            send_sample(value, k == len);
        end
    endtask

    function automatic logic [15:0] aimed_sample(input int target);
        int          span;
        int          mag;
        logic [15:0] v;
        span = (2 * target > FULL_SCALE) ? FULL_SCALE : 2 * target;
        mag = $urandom_range(0, span);
        if ($urandom_range(0, 1) != 0) begin
            v = 16'(-mag);
        end else begin
            v = 16'(mag);
        end
        return v;
    endfunction

    // A negative target asks for raw samples over the full 16-bit range.
    task automatic send_frame(input int target, input int len);
        logic [15:0] smp;
        for (int k = 1; k <= len; k++) begin
            if (target < 0) begin
                smp = 16'($urandom);
            end else begin
                smp = aimed_sample(target);
            end
            send_sample(smp, k == len);
        end
    endtask

    function automatic int frame_len();
        if ($urandom_range(0, 5) == 0) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(1, 8);
    endfunction

    function automatic int loud_target();
        int lo;
        int hi;
        lo = (enter_lvl > FULL_SCALE) ? FULL_SCALE : enter_lvl;
        hi = lo + lo / 2 + 200;
        if (hi > FULL_SCALE) begin
            hi = FULL_SCALE;
        end
        return $urandom_range(lo, hi);
    endfunction

    function automatic int quiet_target();
        if (exit_lvl == 0) begin
            return 0;
        end
        return $urandom_range(0, (exit_lvl > FULL_SCALE ? FULL_SCALE : exit_lvl) - 1);
    endfunction

    task automatic write_reg(input logic [evh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        writes_done++;
    endtask

    // Unused high bits of the narrow registers carry random junk.
    task automatic apply_settings(input logic en, input int enter_l, input int exit_l,
                                  input int hang, input int step);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(evh_pkg::REG_VAD_ENABLE, {junk[15:1], en});
        write_reg(evh_pkg::REG_ENTER_THRESHOLD, enter_l[15:0]);
        write_reg(evh_pkg::REG_EXIT_THRESHOLD, exit_l[15:0]);
        write_reg(evh_pkg::REG_HANGOVER_MS, hang[15:0]);
        write_reg(evh_pkg::REG_FRAME_DURATION_MS, {junk[7:0], step[7:0]});
        enter_lvl = enter_l;
        exit_lvl = exit_l;
        hang_lvl = hang;
        step_ms = step;
    endtask

    task automatic poke_unused_indexes();
        logic [evh_pkg::CFG_IDX_W-1:0] idx;
        for (int i = int'(evh_pkg::REG_FRAME_DURATION_MS) + 1;
             i < (1 << evh_pkg::CFG_IDX_W); i++) begin
            idx = evh_pkg::CFG_IDX_W'(i);
            write_reg(idx, 16'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        while (frames_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic speech_episode();
        int quiet_frames;
        repeat ($urandom_range(1, 3)) send_frame(loud_target(), frame_len());
        quiet_frames = (step_ms == 0) ? 2 : hang_lvl / step_ms + 1;
        if (quiet_frames > 8) begin
            quiet_frames = 8;
        end
        repeat (quiet_frames + $urandom_range(0, 2)) begin
            if ($urandom_range(0, 7) == 0) begin
                send_frame((exit_lvl + enter_lvl) / 2, frame_len());
            end else begin
                send_frame(quiet_target(), frame_len());
            end
        end
    endtask

    task automatic pick_settings(input int ph);
        int step;
        int enter_l;
        step = $urandom_range(10, 200);
        enter_l = $urandom_range(300, 16000);
        case (ph)
            0: apply_settings(1'b1, 0, 65535, 65535, 255);
            1: apply_settings(1'b1, 20000, 0, 0, 10);
            3: apply_settings(1'b0, enter_l, enter_l / 2, step * 2, step);
            6: apply_settings(1'b1, enter_l, enter_l / 2, $urandom_range(0, 1) * 40, 0);
            7: apply_settings(1'b1, enter_l, enter_l + $urandom_range(0, 2000),
                              step * $urandom_range(0, 4), step);
            default: apply_settings(1'b1, enter_l, $urandom_range(enter_l / 4, enter_l),
                                    step * $urandom_range(0, 4) + $urandom_range(0, step - 1),
                                    step);
        endcase
    endtask

    initial begin
        int quota;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = evh_pkg::REG_VAD_ENABLE;
        cfg_data = '0;
        burst_mode = 1'b0;
        hold_wanted = 1'b0;
        enter_lvl = 800;
        exit_lvl = 500;
        hang_lvl = 500;
        step_ms = 20;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Defaults: silence, entry at full scale, a loud frame, then levels 499 and 500.
        send_run(16'd0, 1);
        send_run(POS_FULL, 1);
        send_sample(NEG_FULL, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_run(16'd499, 1);
        send_sample(16'd500, 1'b0);
        send_sample(16'd501, 1'b1);
        drain();

        // Hangover reached after two quiet frames; no entry possible afterwards.
        apply_settings(1'b1, 65535, 65535, 40, 20);
        send_run(16'd100, 1);
        send_sample(16'd100, 1'b0);
        send_sample(16'd101, 1'b1);
        send_run(NEG_FULL, 1);
        drain();

        // Zero thresholds, zero hangover and a zero frame duration.
        apply_settings(1'b1, 0, 0, 0, 0);
        send_run(16'd0, 1);
        send_run(16'd0, 1);
        drain();
        write_reg(evh_pkg::REG_EXIT_THRESHOLD, 16'hFFFF);
        exit_lvl = 65535;
        send_run(16'd3, 1);
        send_run(16'd9, 1);
        drain();

        // Detection off while speaking, a frame past capacity ending on a dropped
        // sample, and writes to indexes that do not exist.
        write_reg(evh_pkg::REG_VAD_ENABLE, 16'hFFFE);
        poke_unused_indexes();
        burst_mode = 1'b1;
        send_run(NEG_FULL, OVERLONG_LEN);
        burst_mode = 1'b0;
        send_run(16'd7, 1);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            pick_settings(ph);
            quota = items_sent + RANDOM_ITEMS / PHASES;
            if (ph == 2) begin
                // The result side holds off while short frames keep arriving.
                hold_wanted = 1'b1;
                burst_mode = 1'b1;
                repeat (30) send_frame(-1, $urandom_range(1, 2));
            end
            while (items_sent < quota) begin
                burst_mode = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 7))
                    0: send_frame(-1, frame_len());
                    1: send_frame($urandom_range(0, FULL_SCALE), frame_len());
                    default: speech_episode();
                endcase
            end
            burst_mode = 1'b0;
            drain();
        end

        $display("Sent %0d samples and %0d register writes; %0d frame results were checked.",
                 items_sent, writes_done, frames_seen);
        $display("Results included %0d speech state changes and %0d overlong frames.",
                 toggles_seen, overlong_seen);
        if (mismatches == 0 && frames_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
